### hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared definitions of the first-fit block allocator
// Field widths, command and status codes, default pool depth.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int DEF_MAX_CELLS = 128;

	localparam int ID_W   = 16;
	localparam int SIZE_W = 8;
	localparam int CFG_W  = 8;
	localparam int OP_W   = 2;
	localparam int STS_W  = 2;

	// command codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_NULL    = 2'd1;
	localparam logic [STS_W-1:0] STS_ILLEGAL = 2'd2;

endpackage

### hw/rtl/ffba_cell_ram.sv
// ----------------------------------------------------------------------------
// ffba_cell_ram: owner store of the allocator
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_cell_ram #(
	parameter int DEPTH = ffba_pkg::DEF_MAX_CELLS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ffba_pkg::ID_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ffba_pkg::ID_W-1:0] rdata
);

	logic [ffba_pkg::ID_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit cell allocator with compaction
// Allocates runs of free cells under fresh ids, erases by id and compacts
// owned cells to the front of the pool, scanning the owner store one cell
// per cycle with a single shared owner compare.
//
// Channel   Signals                              Handshake
// command   op, alloc_size, erase_id             start & !busy
// result    status, granted_id                   done, one cycle, no stall
// config    pool_size                            pool_size_we, any cycle
//
// Busy phases after the accepting edge:
//   allocate  scan for a fitting free run, then write each granted cell
//   erase     scan the pool; defragment compacting scan, then zero the tail
//   a zero-sized or exhausted allocate, or an erase of id 0, keeps busy low
// The scan reads one cell per cycle from the registered store read port.
// A clearing pass after reset zeroes the store, with busy high. Done never
// pulses for a defragment or a successful erase. Results cannot stall: done
// pulses after the last busy cycle, or the accepting edge if busy stays low.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int MAX_CELLS = ffba_pkg::DEF_MAX_CELLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ffba_pkg::OP_W-1:0]  op,
	input  logic [ffba_pkg::SIZE_W-1:0] alloc_size,
	input  logic [ffba_pkg::ID_W-1:0]  erase_id,
	output logic                       done,
	output logic [ffba_pkg::STS_W-1:0] status,
	output logic [ffba_pkg::ID_W-1:0]  granted_id,
	input  logic                       pool_size_we,
	input  logic [ffba_pkg::CFG_W-1:0] pool_size
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int PW = (CW > ffba_pkg::CFG_W) ? CW : ffba_pkg::CFG_W;
	localparam int LW = (CW > ffba_pkg::SIZE_W) ? CW : ffba_pkg::SIZE_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FILL
	} state_t;

	state_t                      state_q;
	logic [ffba_pkg::OP_W-1:0]   op_q;
	logic [PW-1:0]               pool_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               wr_q;
	logic [LW-1:0]               run_q;
	logic [LW-1:0]               need_q;
	logic [LW-1:0]               rem_q;
	logic [AW-1:0]               start_q;
	logic [AW-1:0]               wptr_q;
	logic [ffba_pkg::ID_W-1:0]   key_q;
	logic [ffba_pkg::ID_W-1:0]   next_id_q;
	logic                        hit_q;
	logic                        done_q;
	logic [ffba_pkg::STS_W-1:0]  status_q;
	logic [ffba_pkg::ID_W-1:0]   granted_q;
	logic                        rv_s1;
	logic [AW-1:0]               idx_s1;

	logic [CW-1:0]               n_act;
	logic                        rd_en;
	logic [ffba_pkg::ID_W-1:0]   rd_data;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [ffba_pkg::ID_W-1:0]   wr_data;
	logic                        eq;
	logic                        last;
	logic [LW-1:0]               run_inc;
	logic                        fit;
	logic [AW-1:0]               start_sel;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign granted_id = granted_q;

	// clamp the pool size register to 1..MAX_CELLS
	always_comb begin
		if (pool_q == '0) begin
			n_act = CW'(1);
		end else if (pool_q > PW'(MAX_CELLS)) begin
			n_act = CW'(MAX_CELLS);
		end else begin
			n_act = pool_q[CW-1:0];
		end
	end

	// shared owner compare and scan bookkeeping
	assign eq        = (rd_data == key_q);
	assign last      = (CW'(idx_s1) == (n_q - CW'(1)));
	assign run_inc   = run_q + LW'(1);
	assign fit       = eq && (run_inc >= need_q);
	assign start_sel = (run_q == '0) ? idx_s1 : start_q;
	assign rd_en     = (state_q == ST_SCAN) && (cnt_q < n_q);

	// drive the store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_q[AW-1:0];
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
			end
			ST_SCAN: begin
				if (rv_s1 && op_q == ffba_pkg::OP_ERASE) begin
					wr_en   = eq;
					wr_addr = idx_s1;
				end else if (rv_s1 && op_q == ffba_pkg::OP_DEFRAG) begin
					wr_en   = !eq;
					wr_data = rd_data;
				end
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = wptr_q;
				wr_data = next_id_q;
			end
			ST_FILL: begin
				wr_en = (wr_q < n_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	ffba_cell_ram #(
		.DEPTH (MAX_CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	// pool size register, written at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= PW'(MAX_CELLS);
		end else if (pool_size_we) begin
			pool_q <= PW'(pool_size);
		end
	end

	// track read data in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[AW-1:0];
		end
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			op_q      <= ffba_pkg::OP_ALLOC;
			n_q       <= '0;
			cnt_q     <= '0;
			wr_q      <= '0;
			run_q     <= '0;
			need_q    <= '0;
			rem_q     <= '0;
			start_q   <= '0;
			wptr_q    <= '0;
			key_q     <= '0;
			hit_q     <= 1'b0;
			next_id_q <= ffba_pkg::ID_W'(1);
			done_q    <= 1'b0;
			status_q  <= ffba_pkg::STS_OK;
			granted_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q   <= op;
						n_q    <= n_act;
						cnt_q  <= '0;
						wr_q   <= '0;
						run_q  <= '0;
						hit_q  <= 1'b0;
						need_q <= LW'(alloc_size);
						key_q  <= (op == ffba_pkg::OP_ERASE) ? erase_id : '0;
						case (op)
							ffba_pkg::OP_ALLOC: begin
								if (alloc_size == '0 || next_id_q == '0) begin
									done_q    <= 1'b1;
									status_q  <= ffba_pkg::STS_NULL;
									granted_q <= '0;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ffba_pkg::OP_ERASE: begin
								if (erase_id == '0) begin
									done_q    <= 1'b1;
									status_q  <= ffba_pkg::STS_ILLEGAL;
									granted_q <= '0;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ffba_pkg::OP_DEFRAG: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rv_s1) begin
						case (op_q)
							ffba_pkg::OP_ALLOC: begin
								run_q   <= eq ? run_inc : '0;
								start_q <= start_sel;
								if (fit) begin
									wptr_q  <= start_sel;
									rem_q   <= need_q;
									state_q <= ST_WRITE;
								end else if (last) begin
									done_q    <= 1'b1;
									status_q  <= ffba_pkg::STS_NULL;
									granted_q <= '0;
									state_q   <= ST_IDLE;
								end
							end
							ffba_pkg::OP_ERASE: begin
								hit_q <= hit_q | eq;
								if (last) begin
									if (!(hit_q || eq)) begin
										done_q    <= 1'b1;
										status_q  <= ffba_pkg::STS_ILLEGAL;
										granted_q <= '0;
									end
									state_q <= ST_IDLE;
								end
							end
							default: begin
								if (!eq) begin
									wr_q <= wr_q + CW'(1);
								end
								if (last) begin
									state_q <= ST_FILL;
								end
							end
						endcase
					end
				end
				ST_WRITE: begin
					wptr_q <= wptr_q + AW'(1);
					rem_q  <= rem_q - LW'(1);
					if (rem_q == LW'(1)) begin
						done_q    <= 1'b1;
						status_q  <= ffba_pkg::STS_OK;
						granted_q <= next_id_q;
						next_id_q <= next_id_q + ffba_pkg::ID_W'(1);
						state_q   <= ST_IDLE;
					end
				end
				ST_FILL: begin
					if (wr_q < n_q) begin
						wr_q <= wr_q + CW'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a scan never writes the cell it is reading in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != cnt_q[AW-1:0]))
		else $error("cell store write collides with scan read");

	// compaction never writes ahead of the cell being read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rv_s1 && op_q == ffba_pkg::OP_DEFRAG)
			|-> (wr_q <= CW'(idx_s1)))
		else $error("compaction write pointer passed read pointer");

	// a granted id is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ffba_pkg::STS_OK) |-> (granted_q != '0))
		else $error("allocation granted id zero");

	// the id counter moves only with a successful allocate result
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(next_id_q) |-> (done_q && status_q == ffba_pkg::STS_OK))
		else $error("next id changed without a grant");

	// the grant write phase never runs with nothing left to write
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (rem_q != '0))
		else $error("grant write phase with zero cells left");

endmodule
